>>> rtl/core/ab_image_validate_select_defines.svh
// ============================================================================
// ab_image_validate_select_defines.svh - assertion macros
// Shared concurrent assertion wrappers for the image validate/select block.
// ============================================================================
`ifndef AB_IMAGE_VALIDATE_SELECT_DEFINES_SVH
`define AB_IMAGE_VALIDATE_SELECT_DEFINES_SVH

// Check a property on every clock edge outside of reset
`define ABIVS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ABIVS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/abivs_pkg.sv
// ============================================================================
// abivs_pkg - shared types and constants
// Item codes, verdict reasons, image format constants and the CRC update.
// ============================================================================
package abivs_pkg;

  // Image format
  localparam int HDR_BYTES       = 12;
  localparam int POS_W           = 11;
  localparam int PAYLOAD_MAX_DEF = 1024;
  localparam logic [15:0] FORMAT_VERSION_RST = 16'h0001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0] MAGIC [4] = '{8'h4D, 8'h4E, 8'h56, 8'h31};

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_BYTE      = 2'd1,
    KIND_READ_FAIL = 2'd2,
    KIND_SAVE      = 2'd3
  } kind_t;

  // Verdict reasons
  typedef enum logic [2:0] {
    REASON_NONE    = 3'd0,
    REASON_READ    = 3'd1,
    REASON_MAGIC   = 3'd2,
    REASON_VERSION = 3'd3,
    REASON_LENGTH  = 3'd4,
    REASON_CRC     = 3'd5
  } reason_t;

  // Registered input item
  typedef struct packed {
    kind_t      kind;
    logic       sector;
    logic       first;
    logic [7:0] data_byte;
  } item_t;

  // Verdict from the parser for the item in process
  typedef struct packed {
    logic        done;
    logic        ok;
    reason_t     reason;
    logic        sector;
    logic [31:0] seq;
    logic [15:0] length;
  } verdict_t;

  // Selection status after the item in process
  typedef struct packed {
    logic        loaded;
    logic        boot_sector;
    logic [31:0] boot_seq;
    logic        next_target;
    logic [31:0] next_seq;
  } status_t;

  // CRC16-CCITT-FALSE update by one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> rtl/core/ab_image_validate_select.sv
// ============================================================================
// ab_image_validate_select - A/B flash image validator and selector
// Checks streamed sector images and tracks the image to boot and save next.
// ============================================================================
// Each transfer is one item: start load, image byte, read failure or save
// commit. Items pass through an input register and are processed
// combinationally into a result register, so one item is taken every clock
// while the result side keeps up; a stalled result holds the item behind
// it in the input register. An image byte returns a result only when it
// closes a verdict (bad magic, version or length, or the final CRC byte);
// the other kinds always return one. The CRC16 update of a byte is done in
// the same cycle as the header checks. format_version is written through
// cfg_wr_en; the user must write it only while the block is idle (not enforced).
module ab_image_validate_select import abivs_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,
  // Input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // sector[0], first[1], data_byte[9:2], zero[15:10]
  input  logic [1:0]   in_tuser,   // kind[1:0]
  // Result items
  output logic         out_tvalid,
  input  logic         out_tready,
  // image_ok[0], fail_reason[3:1], image_seq[35:4], image_length[51:36],
  // loaded[52], boot_sector[53], boot_seq[85:54], next_target[86],
  // next_seq[118:87], zero[119]
  output logic [119:0] out_tdata,
  output logic         out_tuser   // sector_done[0]
);

  `include "ab_image_validate_select_defines.svh"

  logic [15:0]  format_version_r;
  item_t        item_r;
  logic         in_v_r;
  logic         out_v_r;
  logic [119:0] out_data_r, out_data_nxt;
  logic         out_done_r;
  logic         out_free, advance, res_valid;
  verdict_t     verdict;
  status_t      status;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_version_r <= FORMAT_VERSION_RST;
    end else if (cfg_wr_en) begin
      format_version_r <= cfg_wr_data;
    end
  end

  // Handshake between input register and result register
  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.kind      <= kind_t'(in_tuser);
      item_r.sector    <= in_tdata[0];
      item_r.first     <= in_tdata[1];
      item_r.data_byte <= in_tdata[9:2];
    end
  end

  abivs_parser #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .item           (item_r),
    .format_version (format_version_r),
    .verdict        (verdict)
  );

  abivs_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .kind    (item_r.kind),
    .verdict (verdict),
    .status  (status)
  );

  // Assemble the result
  assign res_valid = (item_r.kind != KIND_BYTE) || verdict.done;

  always_comb begin
    out_data_nxt = {1'b0, status.next_seq, status.next_target, status.boot_seq,
                    status.boot_sector, status.loaded, verdict.length, verdict.seq,
                    verdict.reason, verdict.ok};
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= out_data_nxt;
      out_done_r <= verdict.done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_done_r;

  // Checks
  `ABIVS_ASSERT(a_hold_item, in_v_r && !out_free |=> in_v_r && $stable(item_r), "item dropped")
  `ABIVS_ASSERT(a_save_loads,
    advance && (item_r.kind == KIND_SAVE) |=> out_v_r && out_data_r[52] && !out_done_r,
    "save not loaded")
  `ABIVS_ASSERT(a_load_clears,
    advance && (item_r.kind == KIND_LOAD) |=>
      out_v_r && !out_data_r[52] && (out_data_r[85:54] == 32'd0),
    "load not cleared")
  `ABIVS_ASSERT(a_fail_zero,
    out_v_r && !out_data_r[0] |-> (out_data_r[51:4] == 48'd0),
    "failed verdict carries header")

endmodule

>>> rtl/core/abivs_parser.sv
// ============================================================================
// abivs_parser - image header, length and CRC check
// Tracks the byte position of one sector image and produces its verdict.
// ============================================================================
module abivs_parser import abivs_pkg::*; #(
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  input  item_t       item,
  input  logic [15:0] format_version,
  output verdict_t    verdict
);

  localparam logic [15:0] LEN_MAX = 16'(PAYLOAD_MAX);
  localparam logic [16:0] HDR_EXT = 17'(HDR_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       crch_r, crch_nxt;
  logic             parsing_r, parsing_nxt;
  logic             cur_r, cur_nxt;

  logic [POS_W-1:0] pos_b;
  logic [15:0]      crc_b, crc_new;
  logic [31:0]      seq_b;
  logic [15:0]      len_b;
  logic [7:0]       crch_b;
  logic [16:0]      pos_ext, crc_end;
  logic             byte_hit;

  // Restart values on the first byte of an image
  always_comb begin
    pos_b   = item.first ? '0 : pos_r;
    crc_b   = item.first ? CRC_INIT : crc_r;
    seq_b   = item.first ? '0 : seq_r;
    len_b   = item.first ? '0 : len_r;
    crch_b  = item.first ? '0 : crch_r;
    pos_ext = 17'(pos_b);
    crc_end = HDR_EXT + {1'b0, len_b};
    crc_new = (pos_ext < crc_end) ? crc_byte(crc_b, item.data_byte) : crc_b;
    byte_hit = (item.kind == KIND_BYTE) &&
               (item.first || (parsing_r && (item.sector == cur_r)));
  end

  // Next parse state and verdict
  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    seq_nxt     = seq_r;
    len_nxt     = len_r;
    crch_nxt    = crch_r;
    parsing_nxt = parsing_r;
    cur_nxt     = cur_r;
    verdict     = '0;
    verdict.reason = REASON_NONE;
    case (item.kind)
      KIND_LOAD: begin
        parsing_nxt = 1'b0;
      end
      KIND_READ_FAIL: begin
        parsing_nxt    = 1'b0;
        verdict.done   = 1'b1;
        verdict.reason = REASON_READ;
        verdict.sector = item.sector;
      end
      KIND_BYTE: begin
        if (byte_hit) begin
          parsing_nxt    = 1'b1;
          cur_nxt        = item.first ? item.sector : cur_r;
          pos_nxt        = pos_b + 1'b1;
          crc_nxt        = crc_new;
          seq_nxt        = seq_b;
          len_nxt        = len_b;
          crch_nxt       = crch_b;
          verdict.sector = cur_nxt;
          if (pos_b < POS_W'(4)) begin
            if (item.data_byte != MAGIC[pos_b[1:0]]) begin
              parsing_nxt    = 1'b0;
              verdict.done   = 1'b1;
              verdict.reason = REASON_MAGIC;
            end
          end else if (pos_b == POS_W'(4)) begin
            if (item.data_byte != format_version[15:8]) begin
              parsing_nxt    = 1'b0;
              verdict.done   = 1'b1;
              verdict.reason = REASON_VERSION;
            end
          end else if (pos_b == POS_W'(5)) begin
            if (item.data_byte != format_version[7:0]) begin
              parsing_nxt    = 1'b0;
              verdict.done   = 1'b1;
              verdict.reason = REASON_VERSION;
            end
          end else if (pos_b < POS_W'(10)) begin
            seq_nxt = {seq_b[23:0], item.data_byte};
          end else if (pos_b < POS_W'(HDR_BYTES)) begin
            len_nxt = {len_b[7:0], item.data_byte};
            if ((pos_b == POS_W'(HDR_BYTES - 1)) && (len_nxt > LEN_MAX)) begin
              parsing_nxt    = 1'b0;
              verdict.done   = 1'b1;
              verdict.reason = REASON_LENGTH;
            end
          end else if (pos_ext < crc_end) begin
            // payload byte, CRC only
          end else if (pos_ext == crc_end) begin
            crch_nxt = item.data_byte;
          end else begin
            // last CRC byte closes the image
            parsing_nxt  = 1'b0;
            verdict.done = 1'b1;
            if ({crch_b, item.data_byte} != crc_new) begin
              verdict.reason = REASON_CRC;
            end else begin
              verdict.ok     = 1'b1;
              verdict.seq    = seq_b;
              verdict.length = len_b;
            end
          end
        end
      end
      default: begin
        // save commit leaves the parse alone
      end
    endcase
  end

  // Advance parse state with each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      crc_r     <= CRC_INIT;
      seq_r     <= '0;
      len_r     <= '0;
      crch_r    <= '0;
      parsing_r <= 1'b0;
      cur_r     <= 1'b0;
    end else if (step_en) begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      seq_r     <= seq_nxt;
      len_r     <= len_nxt;
      crch_r    <= crch_nxt;
      parsing_r <= parsing_nxt;
      cur_r     <= cur_nxt;
    end
  end

endmodule

>>> rtl/core/abivs_select.sv
// ============================================================================
// abivs_select - best image selection
// Keeps the selected sector and sequence and derives the next save target.
// ============================================================================
module abivs_select import abivs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  kind_t    kind,
  input  verdict_t verdict,
  output status_t  status
);

  logic        found_r, found_nxt;
  logic        sec_r, sec_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic        better;

  // Update the selection for the item in process
  always_comb begin
    found_nxt = found_r;
    sec_nxt   = sec_r;
    seq_nxt   = seq_r;
    better    = !found_r || (verdict.seq > seq_r) ||
                ((verdict.seq == seq_r) && !verdict.sector && sec_r);
    case (kind)
      KIND_LOAD: begin
        found_nxt = 1'b0;
        sec_nxt   = 1'b0;
        seq_nxt   = '0;
      end
      KIND_SAVE: begin
        found_nxt = 1'b1;
        sec_nxt   = found_r ? ~sec_r : 1'b0;
        seq_nxt   = seq_r + 32'd1;
      end
      KIND_BYTE: begin
        if (verdict.done && verdict.ok && better) begin
          found_nxt = 1'b1;
          sec_nxt   = verdict.sector;
          seq_nxt   = verdict.seq;
        end
      end
      default: begin
        // read failure never changes the selection
      end
    endcase
  end

  // Report the selection as it stands after this item
  always_comb begin
    status.loaded      = found_nxt;
    status.boot_sector = sec_nxt;
    status.boot_seq    = seq_nxt;
    status.next_target = found_nxt ? ~sec_nxt : 1'b0;
    status.next_seq    = seq_nxt + 32'd1;
  end

  // Hold the selection
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      sec_r   <= 1'b0;
      seq_r   <= '0;
    end else if (step_en) begin
      found_r <= found_nxt;
      sec_r   <= sec_nxt;
      seq_r   <= seq_nxt;
    end
  end

endmodule
